@@ hdl/utrb_pkg.sv @@
// Shared types and codes for the UART transmit/receive ring buffer block.
// No dependencies; the ring, the top level and the bench refer to this package.
`default_nettype none

package utrb_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_RX    = 2'd2,
    OP_TXRDY = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TX_FULL  = 2'd1;
  localparam logic [1:0] ST_RX_EMPTY = 2'd2;
  localparam logic [1:0] ST_RX_DROP  = 2'd3;

  // Requests from the operation decoder to one ring queue.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  // Queue condition before the current operation.
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

`default_nettype wire

@@ hdl/utrb_if.sv @@
// Valid/ready channel interfaces for the command and response beats.
// Depends on nothing; the top level uses both.
`default_nettype none

interface utrb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] tx_byte;
  logic [8:0] rx_word;
  logic       frame_error;

  modport source (output valid, operation, tx_byte, rx_word, frame_error, input ready);
  modport sink   (input valid, operation, tx_byte, rx_word, frame_error, output ready);
endinterface

interface utrb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] rx_data;
  logic [7:0] tx_data;
  logic       tx_valid;
  logic       tx_irq_on;
  logic [5:0] rx_level;
  logic [5:0] tx_level;

  modport source (output valid, status, rx_data, tx_data, tx_valid, tx_irq_on, rx_level,
                  tx_level, input ready);
  modport sink   (input valid, status, rx_data, tx_data, tx_valid, tx_irq_on, rx_level,
                  tx_level, output ready);
endinterface

`default_nettype wire

@@ hdl/uart_tx_rx_ring_buffers.sv @@
// Top level of the UART transmit/receive ring buffers: decoder, two queues, response register.
// Depends on utrb_pkg, utrb_if.sv and utrb_ring.
//
// Each command beat is one operation (software put, software get, line receive or
// transmitter ready) and yields exactly one response beat. A command is taken every
// cycle while no response waits unread, and its response appears in the output register
// on the following cycle, held in a single response register with popped bytes from the
// registered queue read ports. The command side stalls only while a response waits
// unread. A queue of DEPTH slots holds at most DEPTH-1 bytes; levels are reported modulo
// 64. Queue storage is not cleared at reset, since only written slots are ever read.
`default_nettype none

module uart_tx_rx_ring_buffers #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  utrb_cmd_if.sink      cmd,
  utrb_rsp_if.source    rsp
);

  logic                 rx_enable;
  logic                 tx_idle, tx_idle_next;
  logic                 accept;
  utrb_pkg::op_t        op;
  utrb_pkg::ring_ctrl_t tx_ctrl, rx_ctrl;
  utrb_pkg::ring_stat_t tx_stat, rx_stat;
  logic [7:0]           tx_q_data, rx_q_data;
  logic [5:0]           tx_level_next, rx_level_next;
  logic [1:0]           status_next;
  logic                 tx_sent_next, rx_got_next;

  // Response register.
  logic                 rsp_valid;
  logic [1:0]           status;
  logic                 tx_sent, rx_got, tx_irq_on;
  logic [5:0]           tx_level, rx_level;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !rsp_valid || rsp.ready;
  assign op        = utrb_pkg::op_t'(cmd.operation);

  always_comb begin
    tx_ctrl      = '0;
    rx_ctrl      = '0;
    status_next  = utrb_pkg::ST_OK;
    tx_idle_next = tx_idle;
    tx_sent_next = 1'b0;
    rx_got_next  = 1'b0;
    unique case (op)
      utrb_pkg::OP_PUT: begin
        if (tx_stat.full) begin
          status_next = utrb_pkg::ST_TX_FULL;
        end else begin
          tx_ctrl.push = 1'b1;
          tx_idle_next = 1'b0;
        end
      end
      utrb_pkg::OP_GET: begin
        if (rx_stat.empty) begin
          status_next = utrb_pkg::ST_RX_EMPTY;
        end else begin
          rx_ctrl.pop = 1'b1;
          rx_got_next = 1'b1;
        end
      end
      utrb_pkg::OP_RX: begin
        if (!rx_enable) begin
          status_next = utrb_pkg::ST_RX_DROP;
        end else begin
          // A framing error empties the queue first, so the byte always fits then.
          rx_ctrl.clear = cmd.frame_error;
          if (!cmd.frame_error && rx_stat.full) begin
            status_next = utrb_pkg::ST_RX_DROP;
          end else begin
            rx_ctrl.push = 1'b1;
          end
        end
      end
      utrb_pkg::OP_TXRDY: begin
        if (tx_stat.empty) begin
          tx_idle_next = 1'b1;
        end else begin
          tx_ctrl.pop  = 1'b1;
          tx_sent_next = 1'b1;
          tx_idle_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      tx_ctrl      = '0;
      rx_ctrl      = '0;
      tx_idle_next = tx_idle;
    end
  end

  utrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (tx_ctrl),
    .wr_data    (cmd.tx_byte),
    .stat       (tx_stat),
    .rd_data    (tx_q_data),
    .level_next (tx_level_next)
  );

  utrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (rx_ctrl),
    .wr_data    (cmd.rx_word[7:0]),
    .stat       (rx_stat),
    .rd_data    (rx_q_data),
    .level_next (rx_level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b0;
      tx_idle   <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rx_enable <= cfg_wr_data;
      end
      tx_idle <= tx_idle_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      tx_sent   <= tx_sent_next;
      rx_got    <= rx_got_next;
      tx_irq_on <= !tx_idle_next;
      tx_level  <= tx_level_next;
      rx_level  <= rx_level_next;
    end
  end

  // The queue read registers hold the popped bytes; other beats report zero.
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = status;
  assign rsp.rx_data   = rx_got ? rx_q_data : 8'd0;
  assign rsp.tx_data   = tx_sent ? tx_q_data : 8'd0;
  assign rsp.tx_valid  = tx_sent;
  assign rsp.tx_irq_on = tx_irq_on;
  assign rsp.rx_level  = rx_level;
  assign rsp.tx_level  = tx_level;

endmodule

`default_nettype wire

@@ hdl/utrb_ring.sv @@
// One circular byte queue with a slot kept free, a registered read port and a clear.
// Depends on utrb_pkg for the control and status structs.
`default_nettype none

module utrb_ring #(
  parameter int DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire utrb_pkg::ring_ctrl_t  ctrl,
  input  wire logic [7:0]            wr_data,
  output utrb_pkg::ring_stat_t       stat,
  output logic [7:0]                 rd_data,
  output logic [5:0]                 level_next
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem [DEPTH];
  logic [IW-1:0] wr_idx, rd_idx;
  logic [IW-1:0] wr_base, rd_base;
  logic [IW-1:0] wr_idx_next, rd_idx_next;
  logic [IW:0]   count_next;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  always_comb begin
    wr_base     = ctrl.clear ? '0 : wr_idx;
    rd_base     = ctrl.clear ? '0 : rd_idx;
    wr_idx_next = ctrl.push ? step_idx(wr_base) : wr_base;
    rd_idx_next = ctrl.pop ? step_idx(rd_base) : rd_base;
    stat.empty  = (wr_idx == rd_idx);
    stat.full   = (step_idx(wr_idx) == rd_idx);
    if (wr_idx_next >= rd_idx_next) begin
      count_next = {1'b0, wr_idx_next} - {1'b0, rd_idx_next};
    end else begin
      count_next = {1'b0, wr_idx_next} + (IW+1)'(DEPTH) - {1'b0, rd_idx_next};
    end
    level_next = 6'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
    end else begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_base] <= wr_data;
    end
    if (ctrl.pop) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the UART transmit/receive ring buffer block.
// Depends on utrb_pkg, the interfaces in utrb_if.sv and uart_tx_rx_ring_buffers.
`timescale 1ns / 1ps

module tb;
  import utrb_pkg::*;

  typedef struct {
    op_t        op;
    logic [7:0] txb;
    logic [8:0] word;
    logic       ferr;
  } uart_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] rx_data;
    logic [7:0] tx_data;
    logic       tx_valid;
    logic       tx_irq_on;
    logic [5:0] rx_level;
    logic [5:0] tx_level;
  } uart_rsp_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  utrb_cmd_if cmd_ch ();
  utrb_rsp_if rsp_ch ();

  uart_tx_rx_ring_buffers dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch)
  );

  // Shadow copy of both rings and the receive enable.
  logic [7:0] tx_ring_q [64];
  logic [7:0] rx_ring_q [64];
  logic [5:0] tx_wr_ptr, tx_rd_ptr, rx_wr_ptr, rx_rd_ptr;
  logic       tx_idle_q;
  logic       rx_en_q;

  uart_cmd_t cmd_backlog [$];
  uart_rsp_t rsp_expected [$];

  int  errors;
  bit  no_idle;
  int  hold_req;
  int  hold_ack;
  int  send_gap;
  int  recv_gap;
  int  hold_left;

  always #5 clk = ~clk;

  // Applies one operation to the shadow rings and returns the response it yields.
  function uart_rsp_t ring_apply(logic [1:0] op, logic [7:0] txb, logic [8:0] word,
                                 logic ferr);
    uart_rsp_t  r;
    logic [5:0] nxt;
    r.status   = ST_OK;
    r.rx_data  = 8'd0;
    r.tx_data  = 8'd0;
    r.tx_valid = 1'b0;
    case (op_t'(op))
      OP_PUT: begin
        nxt = tx_wr_ptr + 6'd1;
        if (nxt == tx_rd_ptr) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_ring_q[tx_wr_ptr] = txb;
          tx_wr_ptr = nxt;
          tx_idle_q = 1'b0;
        end
      end
      OP_GET: begin
        if (rx_wr_ptr == rx_rd_ptr) begin
          r.status = ST_RX_EMPTY;
        end else begin
          r.rx_data = rx_ring_q[rx_rd_ptr];
          rx_rd_ptr = rx_rd_ptr + 6'd1;
        end
      end
      OP_RX: begin
        if (!rx_en_q) begin
          r.status = ST_RX_DROP;
        end else begin
          // A framing error empties the receive ring before the byte is stored.
          if (ferr) begin
            rx_wr_ptr = 6'd0;
            rx_rd_ptr = 6'd0;
          end
          nxt = rx_wr_ptr + 6'd1;
          if (nxt == rx_rd_ptr) begin
            r.status = ST_RX_DROP;
          end else begin
            rx_ring_q[rx_wr_ptr] = word[7:0];
            rx_wr_ptr = nxt;
          end
        end
      end
      default: begin
        if (tx_wr_ptr != tx_rd_ptr) begin
          r.tx_data  = tx_ring_q[tx_rd_ptr];
          r.tx_valid = 1'b1;
          tx_rd_ptr  = tx_rd_ptr + 6'd1;
          tx_idle_q  = 1'b0;
        end else begin
          tx_idle_q = 1'b1;
        end
      end
    endcase
    r.tx_irq_on = ~tx_idle_q;
    r.rx_level  = rx_wr_ptr - rx_rd_ptr;
    r.tx_level  = tx_wr_ptr - tx_rd_ptr;
    return r;
  endfunction

  // Command driver: one beat per queued command, with a drawn gap after each.
  always @(posedge clk) begin
    uart_cmd_t c;
    bit        held;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        rsp_expected.push_back(ring_apply(cmd_ch.operation, cmd_ch.tx_byte,
                                          cmd_ch.rx_word, cmd_ch.frame_error));
      held = cmd_ch.valid && !cmd_ch.ready;
      if (!held) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          c = cmd_backlog.pop_front();
          cmd_ch.operation   <= c.op;
          cmd_ch.tx_byte     <= c.txb;
          cmd_ch.rx_word     <= c.word;
          cmd_ch.frame_error <= c.ferr;
          cmd_ch.valid       <= 1'b1;
          send_gap           <= no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks every beat and paces ready, including long hold-offs.
  always @(posedge clk) begin
    uart_rsp_t want;
    int        w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: response beat with nothing outstanding: status %0d",
                     $realtime, rsp_ch.status);
        end else begin
          want = rsp_expected.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.rx_data !== want.rx_data ||
              rsp_ch.tx_data !== want.tx_data || rsp_ch.tx_valid !== want.tx_valid ||
              rsp_ch.tx_irq_on !== want.tx_irq_on || rsp_ch.rx_level !== want.rx_level ||
              rsp_ch.tx_level !== want.tx_level) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp st=%0d rx=%h tx=%h txv=%b irq=%b rxl=%0d txl=%0d",
                       $realtime, want.status, want.rx_data, want.tx_data, want.tx_valid,
                       want.tx_irq_on, want.rx_level, want.tx_level);
              $display("%0t: mismatch got st=%0d rx=%h tx=%h txv=%b irq=%b rxl=%0d txl=%0d",
                       $realtime, rsp_ch.status, rsp_ch.rx_data, rsp_ch.tx_data,
                       rsp_ch.tx_valid, rsp_ch.tx_irq_on, rsp_ch.rx_level,
                       rsp_ch.tx_level);
            end
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        hold_left    <= 400;
        recv_gap     <= 0;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_ch.ready <= (hold_left == 1);
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        w = no_idle ? 0 : $urandom_range(0, 7);
        if (w == 0) begin
          rsp_ch.ready <= 1'b1;
        end else begin
          rsp_ch.ready <= 1'b0;
          recv_gap     <= w;
        end
      end else if (!rsp_ch.ready) begin
        if (recv_gap > 1) begin
          recv_gap <= recv_gap - 1;
        end else begin
          recv_gap     <= 0;
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  task automatic queue_cmd(op_t op, logic [7:0] txb, logic [8:0] word, logic ferr);
    uart_cmd_t c;
    c.op   = op;
    c.txb  = txb;
    c.word = word;
    c.ferr = ferr;
    cmd_backlog.push_back(c);
  endtask

  // Returns once every queued command has been taken and answered, plus a short margin.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || rsp_expected.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_rx_enable(bit v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    rx_en_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Queues n commands with the given operation weights and framing error rate.
  task automatic queue_random(int n, int w_put, int w_get, int w_rx, int w_rdy,
                              int ferr_pct, bit burst, bit hold);
    int   pick;
    op_t  op;
    no_idle = burst;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, w_put + w_get + w_rx + w_rdy - 1);
      if (pick < w_put)                    op = OP_PUT;
      else if (pick < w_put + w_get)       op = OP_GET;
      else if (pick < w_put + w_get + w_rx) op = OP_RX;
      else                                 op = OP_TXRDY;
      queue_cmd(op, 8'($urandom), 9'($urandom), $urandom_range(0, 99) < ferr_pct);
    end
    if (hold)
      hold_req++;
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.operation   = OP_PUT;
    cmd_ch.tx_byte     = 8'd0;
    cmd_ch.rx_word     = 9'd0;
    cmd_ch.frame_error = 1'b0;
    rsp_ch.ready       = 1'b0;
    errors             = 0;
    no_idle            = 1'b0;
    hold_req           = 0;
    hold_ack           = 0;
    tx_wr_ptr          = 6'd0;
    tx_rd_ptr          = 6'd0;
    rx_wr_ptr          = 6'd0;
    rx_rd_ptr          = 6'd0;
    tx_idle_q          = 1'b1;
    rx_en_q            = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Receive disabled out of reset: line bytes are dropped with ST_RX_DROP, even with a framing error.
    queue_cmd(OP_GET, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_TXRDY, 8'hFF, 9'h1FF, 1'b1);
    queue_cmd(OP_RX, 8'h00, 9'h1FF, 1'b1);
    queue_cmd(OP_RX, 8'hFF, 9'h000, 1'b0);
    queue_cmd(OP_PUT, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_PUT, 8'hFF, 9'h1FF, 1'b1);
    queue_cmd(OP_TXRDY, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_TXRDY, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_TXRDY, 8'h00, 9'h000, 1'b0);

    set_rx_enable(1'b1);
    queue_cmd(OP_RX, 8'h00, 9'h1FF, 1'b0);
    queue_cmd(OP_RX, 8'h00, 9'h0AA, 1'b0);
    queue_cmd(OP_RX, 8'h00, 9'h155, 1'b1);
    queue_cmd(OP_GET, 8'hFF, 9'h1FF, 1'b1);
    queue_cmd(OP_GET, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_RX, 8'h00, 9'h100, 1'b0);
    queue_cmd(OP_RX, 8'h00, 9'h0FF, 1'b1);
    queue_cmd(OP_GET, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_PUT, 8'h80, 9'h000, 1'b0);
    queue_cmd(OP_PUT, 8'h7F, 9'h000, 1'b0);
    queue_cmd(OP_TXRDY, 8'h00, 9'h000, 1'b0);
    queue_cmd(OP_GET, 8'h00, 9'h000, 1'b0);

    set_rx_enable(1'b1);
    queue_random(150, 25, 25, 25, 25, 10, 1'b0, 1'b0);
    // Fill the transmit ring past full while the receiver stalls for a long stretch.
    set_rx_enable(1'b1);
    queue_random(150, 70, 10, 10, 10, 5, 1'b1, 1'b1);
    // Fill the receive ring; framing errors are rare so that it reaches full.
    set_rx_enable(1'b1);
    queue_random(150, 10, 10, 70, 10, 1, 1'b0, 1'b1);
    set_rx_enable(1'b0);
    queue_random(80, 25, 25, 25, 25, 30, 1'b0, 1'b0);
    set_rx_enable(1'b1);
    queue_random(120, 10, 40, 10, 40, 5, 1'b0, 1'b0);
    set_rx_enable(1'b1);
    queue_random(100, 20, 20, 40, 20, 40, 1'b1, 1'b0);
    set_rx_enable(1'b0);
    queue_random(20, 30, 30, 20, 20, 50, 1'b0, 1'b0);
    set_rx_enable(1'b1);
    queue_random(150, 25, 25, 25, 25, 3, 1'b1, 1'b0);
    set_rx_enable(1'b1);
    queue_random(150, 40, 8, 45, 7, 1, 1'b0, 1'b1);

    wait_drained();
    repeat (5) @(posedge clk);
    if (errors == 0 && rsp_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
